// ===== rtl/message_pack_deframer_assert.svh =====
`ifndef MESSAGE_PACK_DEFRAMER_ASSERT_SVH
`define MESSAGE_PACK_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during reset
`define MPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mpd_pkg.sv =====
`default_nettype none

package mpd_pkg;

  // Parser phase; DONE holds off everything until the next start marker
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_MESSAGE,
    PH_RAW,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_RAW,
    KIND_STATUS
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_HEADER,
    ST_LENGTH,
    ST_CHECKSUM,
    ST_OVERFLOW
  } status_t;

  // One result as it travels from front to back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  cmd;
    logic [7:0]  flags;
    logic        last;
    status_t     status;
  } mpd_item_t;

  localparam logic [7:0] CHK_BASE   = 8'hAA;
  localparam logic [7:0] NO_CHECK   = 8'h88;
  localparam int         HDR_BYTES  = 4;
  localparam int         SIZE_EXTRA = 3;
  // Compare width: covers 17-bit message length and a counter up to 17 bits + 1
  localparam int         CMP_W      = 18;
  localparam int         MLEN_W     = 17;
  localparam int         QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// ===== rtl/mpd_front.sv =====
`default_nettype none

module mpd_front import mpd_pkg::*; #(
  parameter int MAX_PACK_BYTES = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_protocol_flags,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_start_of_pack,
  input  wire logic       q_ready,
  output logic            q_push,
  output mpd_item_t       q_item
);

  localparam int CNT_W = $clog2(MAX_PACK_BYTES);

  phase_t                phase_r, phase_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [15:0]           plen_r, plen_nxt;
  logic [MLEN_W-1:0]     mlen_r, mlen_nxt;
  logic [7:0]            flags_r, flags_nxt;
  logic [7:0]            sum_r, sum_nxt;
  logic [7:0]            cmd_r, cmd_nxt;
  logic [7:0]            proto_r;

  // State as seen by this request: a start marker clears it first
  phase_t                ph_eff;
  logic [CNT_W-1:0]      pos;
  logic [15:0]           plen_eff;
  logic [MLEN_W-1:0]     mlen_eff;
  logic [7:0]            flags_eff, sum_eff, cmd_eff;

  logic                  accept;
  logic [7:0]            b;
  logic [CMP_W-1:0]      pos_p1;
  logic [7:0]            sum_add;
  logic [MLEN_W-1:0]     mlen_new;
  logic                  hdr_bad, hdr_ovf, is_proto;
  logic                  mlen_bad, in_payload, raw_last, ck_ok;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign b        = in_rx_byte;

  assign ph_eff    = in_start_of_pack ? PH_HEADER : phase_r;
  assign pos       = in_start_of_pack ? '0 : cnt_r;
  assign plen_eff  = in_start_of_pack ? '0 : plen_r;
  assign mlen_eff  = in_start_of_pack ? '0 : mlen_r;
  assign flags_eff = in_start_of_pack ? '0 : flags_r;
  assign sum_eff   = in_start_of_pack ? '0 : sum_r;
  assign cmd_eff   = in_start_of_pack ? '0 : cmd_r;

  // Shared decisions
  assign pos_p1     = CMP_W'(pos) + CMP_W'(1);
  assign sum_add    = sum_eff + b;
  assign mlen_new   = MLEN_W'({b, mlen_eff[7:0]}) + MLEN_W'(SIZE_EXTRA);
  assign hdr_bad    = (sum_eff != b);
  assign hdr_ovf    = (CMP_W'(plen_eff) + CMP_W'(HDR_BYTES)) > CMP_W'(MAX_PACK_BYTES);
  assign is_proto   = (flags_eff == proto_r);
  assign mlen_bad   = (mlen_new < MLEN_W'(HDR_BYTES)) ||
                      (CMP_W'(mlen_new) > CMP_W'(plen_eff));
  assign in_payload = pos_p1 < CMP_W'(mlen_eff);
  assign raw_last   = pos_p1 >= CMP_W'(plen_eff);
  assign ck_ok      = (b == NO_CHECK) || (b == (CHK_BASE - sum_eff));

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    plen_nxt  = plen_r;
    mlen_nxt  = mlen_r;
    flags_nxt = flags_r;
    sum_nxt   = sum_r;
    cmd_nxt   = cmd_r;
    if (accept) begin
      phase_nxt = ph_eff;
      cnt_nxt   = pos;
      plen_nxt  = plen_eff;
      mlen_nxt  = mlen_eff;
      flags_nxt = flags_eff;
      sum_nxt   = sum_eff;
      cmd_nxt   = cmd_eff;
      if (ph_eff != PH_DONE) begin
        cnt_nxt = pos + CNT_W'(1);
      end
      case (ph_eff)
        PH_HEADER: begin
          if (pos < CNT_W'(3)) begin
            sum_nxt = sum_add;
            if (pos == CNT_W'(0)) begin
              flags_nxt = b;
            end else if (pos == CNT_W'(1)) begin
              plen_nxt = {8'h00, b};
            end else begin
              plen_nxt = {b, plen_eff[7:0]};
            end
          end else if (hdr_bad || hdr_ovf) begin
            phase_nxt = PH_DONE;
          end else begin
            cnt_nxt = '0;
            sum_nxt = '0;
            if (is_proto) begin
              phase_nxt = (plen_eff < 16'(HDR_BYTES)) ? PH_DONE : PH_MESSAGE;
            end else begin
              phase_nxt = (plen_eff == 16'd0) ? PH_DONE : PH_RAW;
            end
          end
        end
        PH_MESSAGE: begin
          if (pos == CNT_W'(0)) begin
            cmd_nxt = b;
            sum_nxt = b;
          end else if (pos == CNT_W'(1)) begin
            mlen_nxt = MLEN_W'(b);
            sum_nxt  = sum_add;
          end else if (pos == CNT_W'(2)) begin
            mlen_nxt = mlen_new;
            sum_nxt  = sum_add;
            if (mlen_bad) begin
              phase_nxt = PH_DONE;
            end
          end else if (in_payload) begin
            sum_nxt = sum_add;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_RAW: begin
          if (raw_last) begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  // Result for this request, if any
  always_comb begin
    q_push        = 1'b0;
    q_item.kind   = KIND_STATUS;
    q_item.data   = 8'h00;
    q_item.cmd    = cmd_eff;
    q_item.flags  = flags_eff;
    q_item.last   = 1'b1;
    q_item.status = ST_OK;
    case (ph_eff)
      PH_HEADER: begin
        if (pos >= CNT_W'(3)) begin
          if (hdr_bad) begin
            q_push        = accept;
            q_item.status = ST_HEADER;
          end else if (hdr_ovf) begin
            q_push        = accept;
            q_item.status = ST_OVERFLOW;
          end else if (is_proto) begin
            q_push        = accept && (plen_eff < 16'(HDR_BYTES));
            q_item.status = ST_LENGTH;
          end else begin
            q_push        = accept && (plen_eff == 16'd0);
          end
        end
      end
      PH_MESSAGE: begin
        if (pos == CNT_W'(2)) begin
          q_push        = accept && mlen_bad;
          q_item.status = ST_LENGTH;
        end else if (pos > CNT_W'(2)) begin
          q_push = accept;
          if (in_payload) begin
            q_item.kind = KIND_PAYLOAD;
            q_item.data = b;
            q_item.last = 1'b0;
          end else begin
            q_item.status = ck_ok ? ST_OK : ST_CHECKSUM;
          end
        end
      end
      PH_RAW: begin
        q_push      = accept;
        q_item.kind = KIND_RAW;
        q_item.data = b;
        q_item.last = raw_last;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      plen_r  <= '0;
      mlen_r  <= '0;
      flags_r <= '0;
      sum_r   <= '0;
      cmd_r   <= '0;
      proto_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      plen_r  <= plen_nxt;
      mlen_r  <= mlen_nxt;
      flags_r <= flags_nxt;
      sum_r   <= sum_nxt;
      cmd_r   <= cmd_nxt;
      if (cfg_valid) begin
        proto_r <= cfg_protocol_flags;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mpd_queue.sv =====
`default_nettype none

module mpd_queue import mpd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  mpd_item_t       push_item,
  output logic            not_full,
  input  wire logic       pop,
  output logic            not_empty,
  output mpd_item_t       head_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mpd_item_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign not_full  = (count_r != CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mpd_back.sv =====
`default_nettype none

module mpd_back import mpd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  mpd_item_t       q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data_byte,
  output logic [3:0]      out_class,
  output logic [2:0]      out_opcode,
  output logic [7:0]      out_pack_flags,
  output logic            out_last,
  output logic [2:0]      out_status
);

  logic       out_valid_r;
  mpd_item_t  item_r;

  // Load when the output stage is empty or being drained
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
  end

  // Split the command byte into category and command
  assign out_valid      = out_valid_r;
  assign out_kind       = item_r.kind;
  assign out_data_byte  = item_r.data;
  assign out_class      = item_r.cmd[7:4];
  assign out_opcode     = item_r.cmd[3:1];
  assign out_pack_flags = item_r.flags;
  assign out_last       = item_r.last;
  assign out_status     = item_r.status;

endmodule

`default_nettype wire

// ===== rtl/message_pack_deframer.sv =====
`default_nettype none

// Channel   Direction  Handshake                Payload
// cfg       in         cfg_valid / cfg_ready    cfg_protocol_flags
// in        in         in_valid  / in_ready     in_rx_byte, in_start_of_pack
// out       out        out_valid / out_ready    out_kind .. out_status
//
// One byte request per cycle while the queue is not full; the result of a byte
// passes through the queue and then the output register before out_valid rises.
// The front parser updates its counters and sums in the accepting cycle; a
// four-entry queue and the output register follow it.
// in_ready drops only while the queue is full; cfg_ready is always high.
// Synchronous active-low reset clears the parser to the header phase and the
// protocol flags to zero.

module message_pack_deframer import mpd_pkg::*; #(
  parameter int MAX_PACK_BYTES = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_protocol_flags,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_start_of_pack,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data_byte,
  output logic [3:0]      out_class,
  output logic [2:0]      out_opcode,
  output logic [7:0]      out_pack_flags,
  output logic            out_last,
  output logic [2:0]      out_status
);

  logic       q_push, q_not_full, q_not_empty, q_pop;
  mpd_item_t  push_item, head_item;

  assign cfg_ready = 1'b1;

  mpd_front #(
    .MAX_PACK_BYTES (MAX_PACK_BYTES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_protocol_flags (cfg_protocol_flags),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_start_of_pack   (in_start_of_pack),
    .q_ready            (q_not_full),
    .q_push             (q_push),
    .q_item             (push_item)
  );

  mpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  mpd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_item         (head_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_class      (out_class),
    .out_opcode     (out_opcode),
    .out_pack_flags (out_pack_flags),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire

// ===== rtl/mpd_checker.sv =====
`default_nettype none

`include "message_pack_deframer_assert.svh"

module mpd_checker import mpd_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_data_byte,
  input wire logic [3:0] out_class,
  input wire logic [2:0] out_opcode,
  input wire logic [7:0] out_pack_flags,
  input wire logic       out_last,
  input wire logic [2:0] out_status
);

  // Whole result payload, for the hold check
  logic [28:0] out_word;

  assign out_word = {out_kind, out_data_byte, out_class, out_opcode, out_pack_flags,
                     out_last, out_status};

  // A stalled result holds
  `MPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result changed while stalled")

  // A status item always closes the pack
  `MPD_ASSERT_SAME(a_status_last, out_valid && out_kind == KIND_STATUS, out_last, "status item without last")

  // Errors only on a final status item
  `MPD_ASSERT_SAME(a_err_final, out_valid && out_status != ST_OK, out_last && out_kind == KIND_STATUS, "error status on a data item")

  // Raw data never carries message fields
  `MPD_ASSERT_SAME(a_raw_clean, out_valid && out_kind == KIND_RAW, out_class == 4'd0 && out_opcode == 3'd0 && out_status == ST_OK, "raw item with message fields")

endmodule

bind message_pack_deframer mpd_checker u_mpd_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
  import mpd_pkg::*;

  localparam int MAX_PACK       = 4096;
  localparam int ITEM_TARGET    = 1050;
  localparam int SUB_PHASES     = 6;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  // how the message trailer byte is formed
  typedef enum int {
    SUM_GOOD,
    SUM_NONE,
    SUM_RANDOM
  } trailer_t;

  // one deframed item as the block should present it
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [3:0] category;
    logic [2:0] command;
    logic [7:0] flags;
    logic       last;
    status_t    status;
  } deframed_t;

  // Parser mirror plus the queue of deframed items still owed by the block
  class deframe_scoreboard;
    logic [7:0]  proto_flags;
    phase_t      phase;
    logic [16:0] count;
    logic [15:0] hdr_length;
    logic [16:0] msg_len;
    logic [7:0]  flags;
    logic [7:0]  sum;
    logic [7:0]  cmd;
    logic        done;
    deframed_t   expected_q[$];
    int          errors;

    function new();
      proto_flags = 8'h00;
      errors      = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      phase      = PH_HEADER;
      count      = '0;
      hdr_length = '0;
      msg_len    = '0;
      flags      = '0;
      sum        = '0;
      cmd        = '0;
      done       = 1'b0;
    endfunction

    function void add_result(kind_t kind, logic [7:0] data, logic last, status_t status);
      deframed_t item;
      item.kind     = kind;
      item.data     = data;
      item.category = cmd[7:4];
      item.command  = cmd[3:1];
      item.flags    = flags;
      item.last     = last;
      item.status   = status;
      expected_q.push_back(item);
    endfunction

    function void close_pack(status_t status);
      done = 1'b1;
      add_result(KIND_STATUS, 8'h00, 1'b1, status);
    endfunction

    // advance the mirror by one accepted byte request
    function void note_request(logic [7:0] b, logic sop);
      int unsigned pos;
      if (sop) clear_parser();
      if (done) return;
      pos   = count;
      count = count + 17'd1;
      case (phase)
        PH_HEADER: begin
          if (pos < 3) begin
            if (pos == 0) flags = b;
            else if (pos == 1) hdr_length = {8'h00, b};
            else hdr_length[15:8] = b;
            sum = sum + b;
          end else if (sum != b) begin
            close_pack(ST_HEADER);
          end else if (HDR_BYTES + int'(hdr_length) > MAX_PACK) begin
            close_pack(ST_OVERFLOW);
          end else begin
            count = '0;
            sum   = '0;
            if (flags == proto_flags) begin
              if (hdr_length < 4) close_pack(ST_LENGTH);
              else phase = PH_MESSAGE;
            end else if (hdr_length == 0) begin
              close_pack(ST_OK);
            end else begin
              phase = PH_RAW;
            end
          end
        end
        PH_RAW: begin
          if (pos + 1 >= hdr_length) begin
            done = 1'b1;
            add_result(KIND_RAW, b, 1'b1, ST_OK);
          end else begin
            add_result(KIND_RAW, b, 1'b0, ST_OK);
          end
        end
        default: begin
          // message: command, size low, size high, payload, trailer
          if (pos == 0) begin
            cmd = b;
            sum = b;
          end else if (pos == 1) begin
            msg_len = {9'd0, b};
            sum     = sum + b;
          end else if (pos == 2) begin
            msg_len = {1'b0, b, msg_len[7:0]} + 17'd3;
            sum     = sum + b;
            if (msg_len < 4 || msg_len > hdr_length) close_pack(ST_LENGTH);
          end else if (pos + 1 < msg_len) begin
            sum = sum + b;
            add_result(KIND_PAYLOAD, b, 1'b0, ST_OK);
          end else if (b == NO_CHECK || b == CHK_BASE - sum) begin
            close_pack(ST_OK);
          end else begin
            close_pack(ST_CHECKSUM);
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic [3:0] category,
                               logic [2:0] command, logic [7:0] pack_flags, logic last,
                               logic [2:0] status);
      deframed_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual kind %0h data %0h status %0h",
                 $time, kind, data, status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", 8'(want.kind), 8'(kind));
      compare_field("data_byte", want.data, data);
      compare_field("category", 8'(want.category), 8'(category));
      compare_field("command", 8'(want.command), 8'(command));
      compare_field("pack_flags", want.flags, pack_flags);
      compare_field("last", 8'(want.last), 8'(last));
      compare_field("status", 8'(want.status), 8'(status));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_protocol_flags = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_start_of_pack = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic [3:0] out_class;
  logic [2:0] out_opcode;
  logic [7:0] out_pack_flags;
  logic       out_last;
  logic [2:0] out_status;

  deframe_scoreboard sb;
  int          send_idle_pct = 31;
  int          recv_idle_pct = 76;
  int          sent_items = 0;
  int          stall_cycles;
  logic [7:0]  pack_q[$];
  logic        sop_q[$];

  message_pack_deframer #(
    .MAX_PACK_BYTES(MAX_PACK)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_protocol_flags(cfg_protocol_flags),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_start_of_pack  (in_start_of_pack),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_class         (out_class),
    .out_opcode        (out_opcode),
    .out_pack_flags    (out_pack_flags),
    .out_last          (out_last),
    .out_status        (out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_kind, out_data_byte, out_class, out_opcode,
                      out_pack_flags, out_last, out_status);
  end

  // watchdog: too long without any handshake
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // one byte request, with a random gap in front
  task automatic send_byte(input logic [7:0] b, input logic sop);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_rx_byte       <= b;
    in_start_of_pack <= sop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(b, sop);
    sent_items++;
  endtask

  // hold the sender until every owed item is out, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_flags(input logic [7:0] value);
    wait_drained();
    cfg_valid          <= 1'b1;
    cfg_protocol_flags <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.proto_flags = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] b, input logic sop);
    pack_q.push_back(b);
    sop_q.push_back(sop);
  endtask

  task automatic put_header(input logic [7:0] fl, input logic [15:0] len, input bit bad,
                            input logic sop);
    logic [7:0] chk;
    chk = fl + len[7:0] + len[15:8];
    if (bad) chk = chk ^ 8'($urandom_range(1, 255));
    put_byte(fl, sop);
    put_byte(len[7:0], 1'b0);
    put_byte(len[15:8], 1'b0);
    put_byte(chk, 1'b0);
  endtask

  task automatic put_message(input logic [7:0] cmd, input logic [15:0] size,
                             input int unsigned plen, input trailer_t how);
    logic [7:0] sum;
    logic [7:0] b;
    sum = cmd + size[7:0] + size[15:8];
    put_byte(cmd, 1'b0);
    put_byte(size[7:0], 1'b0);
    put_byte(size[15:8], 1'b0);
    repeat (plen) begin
      b   = 8'($urandom);
      sum = sum + b;
      put_byte(b, 1'b0);
    end
    case (how)
      SUM_GOOD: put_byte(CHK_BASE - sum, 1'b0);
      SUM_NONE: put_byte(NO_CHECK, 1'b0);
      default:  put_byte(8'($urandom), 1'b0);
    endcase
  endtask

  task automatic send_pack();
    foreach (pack_q[i]) send_byte(pack_q[i], sop_q[i]);
    pack_q.delete();
    sop_q.delete();
  endtask

  function automatic trailer_t pick_trailer();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return SUM_GOOD;
    if (r < 85) return SUM_NONE;
    return SUM_RANDOM;
  endfunction

  // mostly well-formed packs with random content, the rest broken or noise
  task automatic random_pack();
    int unsigned pick, plen, len, cut;
    logic [7:0]  fl;
    if ($urandom_range(0, 99) < 3) wait_drained();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      len  = ($urandom_range(0, 49) == 0) ? MAX_PACK - HDR_BYTES
                                          : plen + 4 + $urandom_range(0, 3);
      put_header(sb.proto_flags, 16'(len), 1'b0, 1'b1);
      put_message(8'($urandom), 16'(plen + 1), plen, pick_trailer());
    end else if (pick < 65) begin
      // raw pack
      fl  = 8'($urandom);
      len = $urandom_range(0, 12);
      put_header(fl, 16'(len), 1'b0, 1'b1);
      repeat (len) put_byte(8'($urandom), 1'b0);
    end else begin
      case ($urandom_range(0, 6))
        0: put_header(8'($urandom), 16'($urandom_range(0, 20)), 1'b1, 1'b1);
        1: put_header(($urandom_range(0, 1) != 0) ? sb.proto_flags : 8'($urandom),
                      16'($urandom_range(MAX_PACK - HDR_BYTES + 1, 65535)), 1'b0, 1'b1);
        2: put_header(sb.proto_flags, 16'($urandom_range(0, 3)), 1'b0, 1'b1);
        3: begin
          // size field of zero
          put_header(sb.proto_flags, 16'($urandom_range(4, 8)), 1'b0, 1'b1);
          put_message(8'($urandom), 16'h0000, $urandom_range(0, 2), SUM_RANDOM);
        end
        4: begin
          // message longer than its pack
          plen = $urandom_range(1, 8);
          put_header(sb.proto_flags, 16'($urandom_range(4, plen + 3)), 1'b0, 1'b1);
          if ($urandom_range(0, 3) == 0)
            put_message(8'($urandom), 16'hFFFF, plen, SUM_GOOD);
          else
            put_message(8'($urandom), 16'(plen + 1), plen, SUM_GOOD);
        end
        5: begin
          // pack cut short by the next start marker
          plen = $urandom_range(0, 8);
          if ($urandom_range(0, 1) != 0) begin
            put_header(sb.proto_flags, 16'(plen + 4), 1'b0, 1'b1);
            put_message(8'($urandom), 16'(plen + 1), plen, SUM_GOOD);
          end else begin
            put_header(8'($urandom), 16'(plen + 2), 1'b0, 1'b1);
            repeat (plen + 2) put_byte(8'($urandom), 1'b0);
          end
          cut = $urandom_range(1, pack_q.size() - 1);
          while (pack_q.size() > cut) begin
            void'(pack_q.pop_back());
            void'(sop_q.pop_back());
          end
        end
        default: begin
          // noise
          repeat ($urandom_range(1, 8))
            put_byte(8'($urandom), $urandom_range(0, 4) == 0);
        end
      endcase
    end
    // trailing padding, ignored until the next marker once the pack has closed
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
    send_pack();
  endtask

  initial begin
    int base;
    logic [7:0] flag_plan [SUB_PHASES];
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: protocol flags still at reset value
    // message before any marker, one payload byte, no-check trailer
    put_header(8'h00, 16'd5, 1'b0, 1'b0);
    put_message(8'hFF, 16'd2, 1, SUM_NONE);
    // header checksum wrong
    put_header(8'hFF, 16'd0, 1'b1, 1'b1);
    // oversized pack
    put_header(8'h3C, 16'hFFFF, 1'b0, 1'b1);
    // one-byte raw pack
    put_header(8'h80, 16'd1, 1'b0, 1'b1);
    put_byte(8'hFF, 1'b0);
    // protocol pack too short for a message
    put_header(8'h00, 16'd3, 1'b0, 1'b1);
    send_pack();

    flag_plan[0] = 8'hFF;
    flag_plan[1] = 8'($urandom);
    flag_plan[2] = 8'h00;
    flag_plan[3] = 8'($urandom);
    flag_plan[4] = 8'($urandom);
    flag_plan[5] = 8'h01;

    // random phases: receiver-heavy idling, sender-heavy, then none
    for (int ph = 0; ph < SUB_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 76;
      end else if (ph < 4) begin
        send_idle_pct = 76;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_flags(flag_plan[ph]);
      base = sent_items;
      while (sent_items - base < ITEM_TARGET / SUB_PHASES) random_pack();
    end

    wait_drained();
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== message_pack_deframer.f =====
+incdir+rtl
rtl/mpd_pkg.sv
rtl/mpd_front.sv
rtl/mpd_queue.sv
rtl/mpd_back.sv
rtl/message_pack_deframer.sv
rtl/mpd_checker.sv
bench/tb_top.sv
